FILE: hdl/dbtf_pkg.sv
`timescale 1ns / 1ps
package dbtf_pkg;

    localparam int BYTES_PER_LINE_DEF = 80;
    localparam int LINES_DEF          = 480;

    // Widest byte address over the whole parameter range (256 x 1024 bytes)
    localparam int ADDR_W_MAX  = 18;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [1:0] OP_PIXEL = 2'd0;
    localparam logic [1:0] OP_GLYPH = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    localparam logic [3:0] ROW_STRIKE    = 4'd8;
    localparam logic [3:0] ROW_UNDERLINE = 4'd14;

    localparam logic [7:0] P0_ODD  [8] = '{8'h00, 8'h55, 8'h55, 8'h55,
                                           8'hff, 8'hff, 8'hff, 8'hff};
    localparam logic [7:0] P0_EVEN [8] = '{8'h00, 8'haa, 8'haa, 8'haa,
                                           8'hff, 8'hff, 8'hff, 8'hff};
    localparam logic [7:0] P1_ODD  [8] = '{8'h00, 8'h00, 8'haa, 8'h55,
                                           8'h55, 8'hff, 8'hff, 8'hff};
    localparam logic [7:0] P1_EVEN [8] = '{8'h00, 8'h00, 8'h55, 8'haa,
                                           8'haa, 8'hff, 8'hff, 8'hff};

    // One classified command: new = (old & ~mask) | (val & mask)
    typedef struct packed {
        logic                  zero;
        logic [ADDR_W_MAX-1:0] addr;
        logic [7:0]            mask;
        logic [7:0]            val0;
        logic [7:0]            val1;
    } t_cmd;

endpackage

FILE: hdl/dithered_bitplane_text_framebuffer.sv
`timescale 1ns / 1ps
// Path from input word to result word: input register, queue, memory read, then
// modify into the output register; out of range, queue straight to output register.
// An in-range word is read and then written back on the plane memories, and no
// new word leaves the queue meanwhile, nor while a result waits unaccepted.
// Reset: synchronous, active low; the planes are then zeroed one byte per
// cycle, all BYTES_PER_LINE*LINES bytes (38400 by default), before any result.
module dithered_bitplane_text_framebuffer #(
    parameter int BYTES_PER_LINE = dbtf_pkg::BYTES_PER_LINE_DEF,
    parameter int LINES          = dbtf_pkg::LINES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // x[9:0], line[18:10], level[21:19], glyph_bits[29:22], cell_row[33:30],
    // fg[36:34], bg[39:37], attrs[44:40], zero[47:45]
    input  logic [47:0] i_s_axis_tdata,
    // op[1:0]
    input  logic [1:0]  i_s_axis_tuser,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // plane0_byte[7:0], plane1_byte[15:8]
    output logic [15:0] o_m_axis_tdata
);

    logic           push_valid, push_ready;
    dbtf_pkg::t_cmd push_cmd;
    logic           pop_valid, pop_ready;
    dbtf_pkg::t_cmd pop_cmd;
    logic [7:0]     plane0_byte, plane1_byte;

    dbtf_front #(
        .BYTES_PER_LINE (BYTES_PER_LINE),
        .LINES          (LINES)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_s_axis_tvalid),
        .o_ready      (o_s_axis_tready),
        .i_op         (i_s_axis_tuser),
        .i_x          (i_s_axis_tdata[9:0]),
        .i_line       (i_s_axis_tdata[18:10]),
        .i_level      (i_s_axis_tdata[21:19]),
        .i_glyph_bits (i_s_axis_tdata[29:22]),
        .i_cell_row   (i_s_axis_tdata[33:30]),
        .i_fg         (i_s_axis_tdata[36:34]),
        .i_bg         (i_s_axis_tdata[39:37]),
        .i_attrs      (i_s_axis_tdata[44:40]),
        .o_push_valid (push_valid),
        .i_push_ready (push_ready),
        .o_push_cmd   (push_cmd)
    );

    dbtf_fifo u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_cmd   (push_cmd),
        .o_pop_valid  (pop_valid),
        .i_pop_ready  (pop_ready),
        .o_pop_cmd    (pop_cmd)
    );

    dbtf_back #(
        .BYTES_PER_LINE (BYTES_PER_LINE),
        .LINES          (LINES)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_pop_valid   (pop_valid),
        .o_pop_ready   (pop_ready),
        .i_pop_cmd     (pop_cmd),
        .o_valid       (o_m_axis_tvalid),
        .i_ready       (i_m_axis_tready),
        .o_plane0_byte (plane0_byte),
        .o_plane1_byte (plane1_byte)
    );

    assign o_m_axis_tdata = {plane1_byte, plane0_byte};

endmodule

FILE: hdl/dbtf_front.sv
`timescale 1ns / 1ps
module dbtf_front #(
    parameter int BYTES_PER_LINE = dbtf_pkg::BYTES_PER_LINE_DEF,
    parameter int LINES          = dbtf_pkg::LINES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [1:0]          i_op,
    input  logic [9:0]          i_x,
    input  logic [8:0]          i_line,
    input  logic [2:0]          i_level,
    input  logic [7:0]          i_glyph_bits,
    input  logic [3:0]          i_cell_row,
    input  logic [2:0]          i_fg,
    input  logic [2:0]          i_bg,
    input  logic [4:0]          i_attrs,
    output logic                o_push_valid,
    input  logic                i_push_ready,
    output dbtf_pkg::t_cmd      o_push_cmd
);

    localparam int DEPTH  = BYTES_PER_LINE * LINES;
    localparam int ADDR_W = $clog2(DEPTH);

    logic           r_valid, n_valid;
    dbtf_pkg::t_cmd r_cmd, n_cmd;

    logic [6:0]        col;
    logic              in_range;
    logic [ADDR_W-1:0] addr;
    logic              on;
    logic              v0, v1, wr;
    logic [2:0]        f, g;
    logic              odd;
    logic [7:0]        f0, f1, g0, g1;
    logic [7:0]        p;

    assign col      = i_x[9:3];
    assign in_range = (int'(col) < BYTES_PER_LINE) && (int'(i_line) < LINES);
    assign addr     = ADDR_W'(i_line) * ADDR_W'(BYTES_PER_LINE) + ADDR_W'(col);
    assign on       = i_x[0] ^ i_line[0];

    always_comb begin
        v0 = 1'b0;
        v1 = 1'b0;
        wr = 1'b1;
        unique case (i_level)
            3'd0: begin
                v0 = 1'b0;
                v1 = 1'b0;
            end
            3'd1: begin
                v0 = 1'b1;
                v1 = 1'b0;
                wr = on;
            end
            3'd2: begin
                v0 = on;
                v1 = ~on;
            end
            3'd3: begin
                v0 = on;
                v1 = on;
            end
            3'd4: begin
                v0 = on;
                v1 = 1'b1;
            end
            default: begin
                v0 = 1'b1;
                v1 = 1'b1;
            end
        endcase
    end

    assign f   = i_attrs[4] ? i_bg : i_fg;
    assign g   = i_attrs[4] ? i_fg : i_bg;
    assign odd = i_cell_row[0];
    assign f0  = odd ? dbtf_pkg::P0_ODD[f] : dbtf_pkg::P0_EVEN[f];
    assign f1  = odd ? dbtf_pkg::P1_ODD[f] : dbtf_pkg::P1_EVEN[f];
    assign g0  = odd ? dbtf_pkg::P0_ODD[g] : dbtf_pkg::P0_EVEN[g];
    assign g1  = odd ? dbtf_pkg::P1_ODD[g] : dbtf_pkg::P1_EVEN[g];

    // Bold, then italic slant, then strikethrough
    always_comb begin
        p = i_glyph_bits;
        if (i_attrs[0]) begin
            p = p | (p << 1);
        end
        if (i_attrs[1]) begin
            if (i_cell_row < 4'd6) begin
                p = p << 1;
            end else if (i_cell_row > 4'd7) begin
                p = p >> 1;
            end
        end
        if (i_attrs[2] && (i_cell_row == dbtf_pkg::ROW_STRIKE)) begin
            p = 8'hff;
        end
    end

    always_comb begin
        n_cmd      = r_cmd;
        n_cmd.zero = ~in_range;
        n_cmd.addr = dbtf_pkg::ADDR_W_MAX'(addr);
        n_cmd.mask = 8'h00;
        n_cmd.val0 = 8'h00;
        n_cmd.val1 = 8'h00;
        unique case (i_op)
            dbtf_pkg::OP_PIXEL: begin
                n_cmd.mask = wr ? (8'h01 << i_x[2:0]) : 8'h00;
                n_cmd.val0 = {8{v0}};
                n_cmd.val1 = {8{v1}};
            end
            dbtf_pkg::OP_GLYPH: begin
                n_cmd.mask = 8'hff;
                if ((i_cell_row >= 4'd2) && (i_cell_row <= 4'd13)) begin
                    n_cmd.val0 = (p & f0) | (~p & g0);
                    n_cmd.val1 = (p & f1) | (~p & g1);
                end else if ((i_cell_row == dbtf_pkg::ROW_UNDERLINE) && i_attrs[3]) begin
                    n_cmd.val0 = f0;
                    n_cmd.val1 = f1;
                end else begin
                    n_cmd.val0 = g0;
                    n_cmd.val1 = g1;
                end
            end
            default: begin
                n_cmd.mask = 8'h00;
            end
        endcase
    end

    assign o_ready      = ~r_valid | i_push_ready;
    assign o_push_valid = r_valid;
    assign o_push_cmd   = r_cmd;

    always_comb begin
        n_valid = r_valid;
        if (o_ready) begin
            n_valid = i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_cmd <= n_cmd;
        end
    end

endmodule

FILE: hdl/dbtf_fifo.sv
`timescale 1ns / 1ps
module dbtf_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push_valid,
    output logic           o_push_ready,
    input  dbtf_pkg::t_cmd i_push_cmd,
    output logic           o_pop_valid,
    input  logic           i_pop_ready,
    output dbtf_pkg::t_cmd o_pop_cmd
);

    localparam int PTR_W = $clog2(dbtf_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(dbtf_pkg::QUEUE_DEPTH + 1);

    dbtf_pkg::t_cmd r_mem [dbtf_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             push, pop;

    assign o_push_ready = (r_count != CNT_W'(dbtf_pkg::QUEUE_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_cmd    = r_mem[r_rd_ptr];
    assign push         = i_push_valid & o_push_ready;
    assign pop          = o_pop_valid & i_pop_ready;

    always_comb begin
        n_wr_ptr = push ? r_wr_ptr + PTR_W'(1) : r_wr_ptr;
        n_rd_ptr = pop ? r_rd_ptr + PTR_W'(1) : r_rd_ptr;
        n_count  = r_count;
        if (push && !pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (pop && !push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_cmd;
        end
    end

endmodule

FILE: hdl/dbtf_back.sv
`timescale 1ns / 1ps
module dbtf_back #(
    parameter int BYTES_PER_LINE = dbtf_pkg::BYTES_PER_LINE_DEF,
    parameter int LINES          = dbtf_pkg::LINES_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_pop_valid,
    output logic           o_pop_ready,
    input  dbtf_pkg::t_cmd i_pop_cmd,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [7:0]     o_plane0_byte,
    output logic [7:0]     o_plane1_byte
);

    localparam int DEPTH  = BYTES_PER_LINE * LINES;
    localparam int ADDR_W = $clog2(DEPTH);

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_MOD   = 2'd2;

    logic [7:0] r_plane0 [DEPTH];
    logic [7:0] r_plane1 [DEPTH];

    logic [1:0]        r_state, n_state;
    logic [ADDR_W-1:0] r_clr_addr, n_clr_addr;
    dbtf_pkg::t_cmd    r_cmd;
    logic [7:0]        r_rd0, r_rd1;
    logic              r_out_valid, n_out_valid;
    logic [7:0]        r_out0, r_out1, n_out0, n_out1;
    logic              pop;
    logic              we;
    logic [ADDR_W-1:0] wa, ra;
    logic [7:0]        wd0, wd1, new0, new1;

    assign o_pop_ready = (r_state == ST_IDLE) & (~r_out_valid | i_ready);
    assign pop         = o_pop_ready & i_pop_valid;
    assign ra          = i_pop_cmd.addr[ADDR_W-1:0];

    assign new0 = (r_rd0 & ~r_cmd.mask) | (r_cmd.val0 & r_cmd.mask);
    assign new1 = (r_rd1 & ~r_cmd.mask) | (r_cmd.val1 & r_cmd.mask);

    assign we  = (r_state == ST_CLEAR) | (r_state == ST_MOD);
    assign wa  = (r_state == ST_CLEAR) ? r_clr_addr : r_cmd.addr[ADDR_W-1:0];
    assign wd0 = (r_state == ST_CLEAR) ? 8'h00 : new0;
    assign wd1 = (r_state == ST_CLEAR) ? 8'h00 : new1;

    always_comb begin
        n_state     = r_state;
        n_clr_addr  = r_clr_addr;
        n_out_valid = r_out_valid & ~i_ready;
        n_out0      = r_out0;
        n_out1      = r_out1;
        unique case (r_state)
            ST_CLEAR: begin
                n_clr_addr = r_clr_addr + ADDR_W'(1);
                if (r_clr_addr == ADDR_W'(DEPTH - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (pop) begin
                    if (i_pop_cmd.zero) begin
                        // out of range: no memory write, answer zeros
                        n_out_valid = 1'b1;
                        n_out0      = 8'h00;
                        n_out1      = 8'h00;
                    end else begin
                        n_state = ST_MOD;
                    end
                end
            end
            ST_MOD: begin
                n_out_valid = 1'b1;
                n_out0      = new0;
                n_out1      = new1;
                n_state     = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out0 <= n_out0;
        r_out1 <= n_out1;
        if (pop) begin
            r_cmd <= i_pop_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_plane0[wa] <= wd0;
        end
        r_rd0 <= r_plane0[ra];
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_plane1[wa] <= wd1;
        end
        r_rd1 <= r_plane1[ra];
    end

    assign o_valid       = r_out_valid;
    assign o_plane0_byte = r_out0;
    assign o_plane1_byte = r_out1;

    // the output register is always free when the modify cycle loads it
    a_mod_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MOD) |-> !r_out_valid)
        else $error("modify cycle with result still pending");

    a_mod_after_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MOD) |-> $past(pop) && !$past(i_pop_cmd.zero))
        else $error("modify cycle without an in-range pop");

    a_clear_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR) |-> !pop && !r_out_valid)
        else $error("activity during clearing pass");

    a_clear_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR) && (r_clr_addr == ADDR_W'(DEPTH - 1)) |=>
        (r_state == ST_IDLE))
        else $error("clearing pass did not end");

endmodule

FILE: test/framebuffer_checker.sv
`timescale 1ns / 1ps
module framebuffer_checker #(
    parameter int BYTES_PER_LINE = 80,
    parameter int LINES          = 480
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    input  logic        i_s_axis_tready,
    // x[9:0], line[18:10], level[21:19], glyph_bits[29:22], cell_row[33:30],
    // fg[36:34], bg[39:37], attrs[44:40], zero[47:45]
    input  logic [47:0] i_s_axis_tdata,
    // op[1:0]
    input  logic [1:0]  i_s_axis_tuser,
    input  logic        i_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // plane0_byte[7:0], plane1_byte[15:8]
    input  logic [15:0] i_m_axis_tdata,
    output int          o_errors,
    output int          o_pending,
    output int          o_checked
);

    localparam int PLANE_BYTES = BYTES_PER_LINE * LINES;

    // Grey masks, entry n in bits [8n+7:8n]
    localparam logic [63:0] P0_ODD_MASKS  = 64'hffff_ffff_5555_5500;
    localparam logic [63:0] P0_EVEN_MASKS = 64'hffff_ffff_aaaa_aa00;
    localparam logic [63:0] P1_ODD_MASKS  = 64'hffff_ff55_55aa_0000;
    localparam logic [63:0] P1_EVEN_MASKS = 64'hffff_ffaa_aa55_0000;

    localparam int ATTR_BOLD      = 0;
    localparam int ATTR_ITALIC    = 1;
    localparam int ATTR_STRIKE    = 2;
    localparam int ATTR_UNDERLINE = 3;
    localparam int ATTR_INVERT    = 4;

    localparam logic [3:0] ROW_GLYPH_FIRST    = 4'd2;
    localparam logic [3:0] ROW_GLYPH_LAST     = 4'd13;
    localparam logic [3:0] ROW_SLANT_FLAT_LO  = 4'd6;
    localparam logic [3:0] ROW_SLANT_FLAT_HI  = 4'd7;
    localparam logic [2:0] LEVEL_FULL         = 3'd5;

    logic [7:0]  plane0_shadow [PLANE_BYTES];
    logic [7:0]  plane1_shadow [PLANE_BYTES];
    logic [15:0] expected_planes [$];
    logic [15:0] want_planes;

    initial begin
        o_errors  = 0;
        o_pending = 0;
        o_checked = 0;
    end

    // Run one command on the shadow planes; return {plane1, plane0} after it, zero out of range
    function automatic logic [15:0] apply_command(input logic [1:0] op,
                                                  input logic [47:0] word);
        logic [9:0]  x;
        logic [8:0]  scan_line;
        logic [2:0]  level, fg, bg, fore, back;
        logic [7:0]  glyph, b0, b1, p, f0, f1, g0, g1;
        logic [3:0]  row;
        logic [4:0]  attrs;
        logic [63:0] sel0, sel1;
        logic        on, v0, v1, wr;
        int          col, addr;
        x         = word[9:0];
        scan_line = word[18:10];
        level     = word[21:19];
        glyph     = word[29:22];
        row       = word[33:30];
        fg        = word[36:34];
        bg        = word[39:37];
        attrs     = word[44:40];
        col       = int'(x >> 3);
        if (col >= BYTES_PER_LINE || scan_line >= LINES)
            return 16'h0000;
        addr = int'(scan_line) * BYTES_PER_LINE + col;
        b0 = plane0_shadow[addr];
        b1 = plane1_shadow[addr];
        if (op == dbtf_pkg::OP_PIXEL) begin
            on = x[0] ^ scan_line[0];
            wr = 1'b1;
            v0 = 1'b0;
            v1 = 1'b0;
            if (level >= LEVEL_FULL) begin
                v0 = 1'b1;
                v1 = 1'b1;
            end else if (level == 3'd4) begin
                v0 = on;
                v1 = 1'b1;
            end else if (level == 3'd3) begin
                v0 = on;
                v1 = on;
            end else if (level == 3'd2) begin
                v0 = on;
                v1 = !on;
            end else if (level == 3'd1) begin
                // off phase keeps its old value
                v0 = 1'b1;
                wr = on;
            end
            if (wr) begin
                b0[x[2:0]] = v0;
                b1[x[2:0]] = v1;
            end
        end else if (op == dbtf_pkg::OP_GLYPH) begin
            fore = attrs[ATTR_INVERT] ? bg : fg;
            back = attrs[ATTR_INVERT] ? fg : bg;
            sel0 = row[0] ? P0_ODD_MASKS : P0_EVEN_MASKS;
            sel1 = row[0] ? P1_ODD_MASKS : P1_EVEN_MASKS;
            f0 = sel0[fore*8 +: 8];
            f1 = sel1[fore*8 +: 8];
            g0 = sel0[back*8 +: 8];
            g1 = sel1[back*8 +: 8];
            if (row >= ROW_GLYPH_FIRST && row <= ROW_GLYPH_LAST) begin
                p = glyph;
                if (attrs[ATTR_BOLD])
                    p = p | (p << 1);
                if (attrs[ATTR_ITALIC]) begin
                    if (row < ROW_SLANT_FLAT_LO)
                        p = p << 1;
                    else if (row > ROW_SLANT_FLAT_HI)
                        p = p >> 1;
                end
                if (attrs[ATTR_STRIKE] && row == dbtf_pkg::ROW_STRIKE)
                    p = 8'hff;
                b0 = (p & f0) | (~p & g0);
                b1 = (p & f1) | (~p & g1);
            end else if (row == dbtf_pkg::ROW_UNDERLINE && attrs[ATTR_UNDERLINE]) begin
                b0 = f0;
                b1 = f1;
            end else begin
                b0 = g0;
                b1 = g1;
            end
        end
        plane0_shadow[addr] = b0;
        plane1_shadow[addr] = b1;
        return {b1, b0};
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < PLANE_BYTES; i++) begin
                plane0_shadow[i] = 8'h00;
                plane1_shadow[i] = 8'h00;
            end
            expected_planes.delete();
        end else begin
            // retire the result first: it always belongs to an older word
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                if (expected_planes.size() == 0) begin
                    o_errors++;
                    $display("%0t: unexpected result word, expected none, got %04h",
                             $time, i_m_axis_tdata);
                end else begin
                    want_planes = expected_planes.pop_front();
                    o_checked++;
                    if (want_planes[7:0] !== i_m_axis_tdata[7:0]) begin
                        o_errors++;
                        $display("%0t: plane0 byte mismatch, expected %02h, got %02h",
                                 $time, want_planes[7:0], i_m_axis_tdata[7:0]);
                    end
                    if (want_planes[15:8] !== i_m_axis_tdata[15:8]) begin
                        o_errors++;
                        $display("%0t: plane1 byte mismatch, expected %02h, got %02h",
                                 $time, want_planes[15:8], i_m_axis_tdata[15:8]);
                    end
                end
            end
            if (i_s_axis_tvalid && i_s_axis_tready)
                expected_planes.push_back(apply_command(i_s_axis_tuser, i_s_axis_tdata));
        end
        o_pending = expected_planes.size();
    end

endmodule

FILE: test/tb.sv
`timescale 1ns / 1ps
module tb;

    localparam logic [1:0] OP_SPARE    = 2'd3;
    localparam int         TOTAL_WORDS = 1975;

    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [47:0] i_s_axis_tdata  = '0;
    logic [1:0]  i_s_axis_tuser  = '0;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [15:0] o_m_axis_tdata;

    int          fail_count;
    int          pending_count;
    int          checked_count;
    int          sent_count;
    int          sent_by_op [4];
    int          out_of_range_count;
    int          burst_left;
    logic [15:0] stall_tick = '0;
    logic [1:0]  stall_mode = '0;

    dithered_bitplane_text_framebuffer i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    framebuffer_checker i_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .i_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .i_m_axis_tdata  (o_m_axis_tdata),
        .o_errors        (fail_count),
        .o_pending       (pending_count),
        .o_checked       (checked_count)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Receiver: pick a new random stall pattern each time stall_tick[7:0] returns to zero
    always @(negedge i_clk) begin
        stall_tick <= stall_tick + 16'd1;
        if (stall_tick[7:0] == 8'd0)
            stall_mode <= 2'($urandom_range(0, 3));
        case (stall_mode)
            2'd0: i_m_axis_tready <= 1'b1;
            2'd1: i_m_axis_tready <= (stall_tick % 3) != 0;
            2'd2: i_m_axis_tready <= $urandom_range(0, 3) != 0;
            default: i_m_axis_tready <= stall_tick[4:0] >= 5'd20;
        endcase
    end

    task automatic send_command(input logic [1:0] op, input logic [9:0] x,
                                input logic [8:0] scan_line, input logic [2:0] level,
                                input logic [7:0] glyph, input logic [3:0] row,
                                input logic [2:0] fg, input logic [2:0] bg,
                                input logic [4:0] attrs);
        int gap;
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= op;
        i_s_axis_tdata  <= {3'b000, attrs, bg, fg, row, glyph, level, scan_line, x};
        @(posedge i_clk);
        while (!o_s_axis_tready)
            @(posedge i_clk);
        sent_count++;
        sent_by_op[op]++;
        if ((x >> 3) >= dbtf_pkg::BYTES_PER_LINE_DEF || scan_line >= dbtf_pkg::LINES_DEF)
            out_of_range_count++;
        burst_left--;
        if (burst_left <= 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = ($urandom_range(0, 7) == 0) ? 64 : $urandom_range(1, 24);
            if (gap > 0) begin
                @(negedge i_clk);
                i_s_axis_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
    endtask

    task automatic send_random_at(input logic [1:0] op, input int x, input int scan_line);
        send_command(op, 10'(x), 9'(scan_line), 3'($urandom_range(0, 7)),
                     8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)),
                     3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
                     5'($urandom_range(0, 31)));
    endtask

    // Draw one full 16-line character box, then read it back at two random rows
    task automatic draw_char_box();
        int         col, top;
        logic [2:0] fg, bg;
        logic [4:0] attrs;
        col   = $urandom_range(0, dbtf_pkg::BYTES_PER_LINE_DEF - 1);
        top   = $urandom_range(0, dbtf_pkg::LINES_DEF - 16);
        fg    = 3'($urandom_range(0, 7));
        bg    = 3'($urandom_range(0, 7));
        attrs = 5'($urandom_range(0, 31));
        for (int r = 0; r < 16; r++)
            send_command(dbtf_pkg::OP_GLYPH, 10'(col * 8 + $urandom_range(0, 7)),
                         9'(top + r), 3'($urandom_range(0, 7)),
                         8'($urandom_range(0, 255)), 4'(r), fg, bg, attrs);
        repeat (2)
            send_random_at(dbtf_pkg::OP_READ, col * 8 + $urandom_range(0, 7),
                           top + $urandom_range(0, 15));
    endtask

    function automatic logic [1:0] pick_op();
        int s;
        s = $urandom_range(0, 19);
        if (s < 8)
            return dbtf_pkg::OP_PIXEL;
        else if (s < 15)
            return dbtf_pkg::OP_GLYPH;
        else if (s < 19)
            return dbtf_pkg::OP_READ;
        return OP_SPARE;
    endfunction

    initial begin
        int hot_line, hot_col, r;
        sent_count         = 0;
        out_of_range_count = 0;
        burst_left         = 8;
        foreach (sent_by_op[i])
            sent_by_op[i] = 0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Cleared byte through the spare op, then every level, levels 1 to 4 in both phases
        send_command(OP_SPARE, 0, 0, 0, 0, 0, 0, 0, 0);
        for (int lvl = 0; lvl < 8; lvl++)
            send_command(dbtf_pkg::OP_PIXEL, 10'(lvl), 0, 3'(lvl), 8'hff, 0, 7, 7, 5'h1f);
        send_command(dbtf_pkg::OP_PIXEL, 9, 0, 2, 0, 0, 0, 0, 0);
        send_command(dbtf_pkg::OP_PIXEL, 10, 0, 3, 0, 0, 0, 0, 0);
        send_command(dbtf_pkg::OP_PIXEL, 11, 0, 4, 0, 0, 0, 0, 0);
        // level 1 on an off-phase pixel must leave the full-on value
        send_command(dbtf_pkg::OP_PIXEL, 12, 0, 7, 0, 0, 0, 0, 0);
        send_command(dbtf_pkg::OP_PIXEL, 12, 0, 1, 0, 0, 0, 0, 0);

        // Glyph rows in the last byte column of the screen
        send_command(dbtf_pkg::OP_GLYPH, 639, 464, 0, 8'hff, 0, 7, 3, 5'h00);
        send_command(dbtf_pkg::OP_GLYPH, 639, 465, 0, 8'hff, 1, 2, 5, 5'h10);
        send_command(dbtf_pkg::OP_GLYPH, 639, 467, 0, 8'h81, 3, 7, 0, 5'h03);
        send_command(dbtf_pkg::OP_GLYPH, 639, 472, 0, 8'h00, 8, 6, 1, 5'h04);
        send_command(dbtf_pkg::OP_GLYPH, 639, 474, 0, 8'hff, 10, 4, 2, 5'h12);
        send_command(dbtf_pkg::OP_GLYPH, 639, 478, 0, 8'h00, 14, 3, 0, 5'h08);
        send_command(dbtf_pkg::OP_GLYPH, 639, 478, 0, 8'hff, 14, 3, 4, 5'h17);
        send_command(dbtf_pkg::OP_GLYPH, 639, 479, 0, 8'hff, 15, 7, 1, 5'h1f);

        // Out of range addresses write nothing and read zero
        send_command(dbtf_pkg::OP_PIXEL, 640, 0, 7, 0, 0, 0, 0, 0);
        send_command(dbtf_pkg::OP_GLYPH, 0, 480, 0, 8'hff, 5, 7, 7, 5'h1f);
        send_command(dbtf_pkg::OP_READ, 1023, 511, 7, 8'hff, 15, 7, 7, 5'h1f);
        send_command(dbtf_pkg::OP_READ, 639, 479, 0, 0, 0, 0, 0, 0);

        hot_line = 0;
        hot_col  = 0;
        while (sent_count < TOTAL_WORDS) begin
            // move the busy region now and then so neighbors get overwritten
            if ($urandom_range(0, 63) == 0 || sent_count == 25) begin
                hot_line = $urandom_range(0, dbtf_pkg::LINES_DEF - 4);
                hot_col  = $urandom_range(0, dbtf_pkg::BYTES_PER_LINE_DEF - 2);
            end
            if ($urandom_range(0, 15) == 0) begin
                draw_char_box();
            end else begin
                r = $urandom_range(0, 99);
                if (r < 70)
                    send_random_at(pick_op(), hot_col * 8 + $urandom_range(0, 15),
                                   hot_line + $urandom_range(0, 3));
                else if (r < 90)
                    send_random_at(pick_op(), $urandom_range(0, 639),
                                   $urandom_range(0, dbtf_pkg::LINES_DEF - 1));
                else if (r < 95)
                    send_random_at(pick_op(), $urandom_range(640, 1023),
                                   $urandom_range(0, 511));
                else
                    send_random_at(pick_op(), $urandom_range(0, 1023),
                                   $urandom_range(dbtf_pkg::LINES_DEF, 511));
            end
        end

        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;
        while (pending_count != 0)
            @(negedge i_clk);
        // catch any stray result after the last expected one
        repeat (20) @(posedge i_clk);

        $display("Sent %0d words: %0d pixel, %0d glyph, %0d read, %0d spare op, %0d out of range.",
                 sent_count, sent_by_op[dbtf_pkg::OP_PIXEL], sent_by_op[dbtf_pkg::OP_GLYPH],
                 sent_by_op[dbtf_pkg::OP_READ], sent_by_op[OP_SPARE], out_of_range_count);
        $display("Checked %0d result words under varying sender bursts and receiver stalls.",
                 checked_count);
        if (fail_count == 0 && pending_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Timeout with %0d results still outstanding.", pending_count);
        $display("DONE: errors detected");
        $finish;
    end

endmodule

FILE: sim.f
hdl/dbtf_pkg.sv
hdl/dbtf_front.sv
hdl/dbtf_fifo.sv
hdl/dbtf_back.sv
hdl/dithered_bitplane_text_framebuffer.sv
test/framebuffer_checker.sv
test/tb.sv
